// File: src/tnva_pkg.sv
// ----------------------------------------------------------------------------
// tnva_pkg
// Shared types, widths and helpers for the timed note voice allocator.
// ----------------------------------------------------------------------------
package tnva_pkg;

  // Pool size and derived index width
  localparam int VOICE_COUNT = 8;
  localparam int SLOT_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  // Field widths
  localparam int NOTE_W       = 7;
  localparam int VEL_W        = 7;
  localparam int HOLD_W       = 16;
  localparam int CHAN_W       = 5;
  localparam int SLOT_FIELD_W = 5;
  localparam int TIME_W       = 32;

  // Bus widths
  localparam int S_DATA_W    = 40;
  localparam int M_DATA_W    = 24;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;

  typedef logic [SLOT_W-1:0]      slot_idx_t;
  typedef logic [VOICE_COUNT-1:0] slot_mask_t;

  // Input item kind (tuser)
  typedef enum logic [0:0] {
    OP_NOTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // Result item kind (tuser)
  typedef enum logic [0:0] {
    KIND_ON  = 1'b0,
    KIND_OFF = 1'b1
  } kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PER_NOTE   = 1'b0,
    REG_DEFAULT_CH = 1'b1
  } cfg_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_TICK,
    ST_MASK,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;
    logic alloc;
    logic now_inc;
    logic mask_load;
    logic emit_off;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic free_any;
    logic mask_any;
    logic mask_last;
    logic out_free;
  } status_t;

  // Index of the lowest set bit (zero when none is set)
  function automatic slot_idx_t lowest_set(input slot_mask_t v);
    slot_idx_t idx;
    idx = '0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: src/tnva_ctrl.sv
// ----------------------------------------------------------------------------
// tnva_ctrl
// Sequencer: takes one item, runs allocation or the tick expiry walk.
// ----------------------------------------------------------------------------
module tnva_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [0:0]        s_tuser,
  input  tnva_pkg::status_t status,
  output tnva_pkg::cmd_t    cmd
);
  import tnva_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch_in = 1'b1;
          state_next   = (s_tuser == OP_TICK) ? ST_TICK : ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        if (!status.free_any) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.alloc  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_TICK: begin
        cmd.now_inc = 1'b1;
        state_next  = ST_MASK;
      end
      ST_MASK: begin
        cmd.mask_load = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status.mask_any) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit_off = 1'b1;
          if (status.mask_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/tnva_datapath.sv
// ----------------------------------------------------------------------------
// tnva_datapath
// Voice slot registers, millisecond clock, expiry mask and result register.
// ----------------------------------------------------------------------------
module tnva_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tnva_pkg::cmd_t                       cmd,
  output tnva_pkg::status_t                    status,
  input  logic [tnva_pkg::S_DATA_W-1:0]        s_tdata,
  input  logic                                 cfg_valid,
  input  logic [tnva_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tnva_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [tnva_pkg::M_DATA_W-1:0]        m_tdata,
  output logic [0:0]                           m_tuser,
  output logic                                 m_tlast
);
  import tnva_pkg::*;

  // Configuration
  logic              per_note_channel;
  logic [CHAN_W-1:0] default_channel;

  // Latched request
  logic [NOTE_W-1:0] req_note;
  logic [VEL_W-1:0]  req_vel;
  logic [HOLD_W-1:0] req_hold;
  logic [CHAN_W-1:0] req_chan;

  // Slot storage
  logic [NOTE_W-1:0] slot_note    [VOICE_COUNT];
  logic [TIME_W-1:0] slot_expiry  [VOICE_COUNT];
  logic [CHAN_W-1:0] slot_channel [VOICE_COUNT];
  slot_mask_t        busy;
  slot_mask_t        expired;
  logic [TIME_W-1:0] now_ms;

  // Result register
  logic [NOTE_W-1:0]       out_note;
  logic [VEL_W-1:0]        out_velocity;
  logic [CHAN_W-1:0]       out_channel;
  logic [SLOT_FIELD_W-1:0] voice_slot;
  logic                    event_kind;
  logic                    last_event;

  // Derived selections
  slot_idx_t  free_idx;
  slot_idx_t  off_idx;
  slot_mask_t off_bit;
  slot_mask_t expired_rest;
  slot_mask_t due;

  assign free_idx     = lowest_set(~busy);
  assign off_idx      = lowest_set(expired);
  assign off_bit      = slot_mask_t'(1) << off_idx;
  assign expired_rest = expired & ~off_bit;

  // Compare every slot against the advanced clock
  always_comb begin
    for (int i = 0; i < VOICE_COUNT; i++) begin
      due[i] = busy[i] && (slot_expiry[i] <= now_ms);
    end
  end

  assign status.free_any  = ~&busy;
  assign status.mask_any  = |expired;
  assign status.mask_last = (expired_rest == '0);
  assign status.out_free  = !m_tvalid || m_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      per_note_channel <= 1'b0;
      default_channel  <= CHAN_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PER_NOTE:   per_note_channel <= cfg_data[0];
        REG_DEFAULT_CH: default_channel  <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_note <= s_tdata[NOTE_W-1:0];
      req_vel  <= s_tdata[NOTE_W +: VEL_W];
      req_hold <= s_tdata[NOTE_W+VEL_W +: HOLD_W];
      req_chan <= s_tdata[NOTE_W+VEL_W+HOLD_W +: CHAN_W];
    end
  end

  // Control state: busy flags and clock
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= '0;
      now_ms <= '0;
    end else begin
      if (cmd.now_inc) begin
        now_ms <= now_ms + TIME_W'(1);
      end
      if (cmd.alloc) begin
        busy[free_idx] <= (req_vel != '0);
      end else if (cmd.emit_off) begin
        busy[off_idx] <= 1'b0;
      end
    end
  end

  // Slot payload and expiry mask
  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      slot_note[free_idx]    <= req_note;
      slot_expiry[free_idx]  <= now_ms + TIME_W'(req_hold);
      slot_channel[free_idx] <= req_chan;
    end
    if (cmd.mask_load) begin
      expired <= due;
    end else if (cmd.emit_off) begin
      expired <= expired_rest;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.alloc || cmd.emit_off) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      event_kind   <= KIND_ON;
      out_note     <= req_note;
      out_velocity <= req_vel;
      out_channel  <= per_note_channel ? req_chan : default_channel;
      voice_slot   <= SLOT_FIELD_W'(free_idx);
      last_event   <= 1'b1;
    end else if (cmd.emit_off) begin
      event_kind   <= KIND_OFF;
      out_note     <= slot_note[off_idx];
      out_velocity <= '0;
      out_channel  <= per_note_channel ? slot_channel[off_idx] : default_channel;
      voice_slot   <= SLOT_FIELD_W'(off_idx);
      last_event   <= (expired_rest == '0);
    end
  end

  assign m_tdata = {voice_slot, out_channel, out_velocity, out_note};
  assign m_tuser = event_kind;
  assign m_tlast = last_event;

endmodule

// File: src/timed_note_voice_allocator.sv
// ----------------------------------------------------------------------------
// timed_note_voice_allocator
// Voice pool with millisecond expiry: a note request takes the lowest free
// slot if any and emits a note-on; ticks emit note-offs for expired slots.
// ----------------------------------------------------------------------------
// Note request: the ALLOC state registers the note-on once the output
//   register is free (none on a full pool); IDLE then takes the next item.
// Tick: TICK advances the clock, MASK loads the expiry mask, then EMIT sends
//   note-offs in slot order, one per cycle unless stalled, then goes to IDLE.
// Reset (rst, synchronous): all slots free, clock at zero, default config.
module timed_note_voice_allocator (
  input  logic                              clk,
  input  logic                              rst,
  // tdata: note_number[6:0], note_velocity[13:7], hold_ms[29:14],
  //        note_channel[34:30], zero pad[39:35]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tnva_pkg::S_DATA_W-1:0]     s_tdata,
  // tuser: opcode[0]
  input  logic [0:0]                        s_tuser,
  // tdata: out_note[6:0], out_velocity[13:7], out_channel[18:14],
  //        voice_slot[23:19]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tnva_pkg::M_DATA_W-1:0]     m_tdata,
  // tuser: event_kind[0]
  output logic [0:0]                        m_tuser,
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tnva_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tnva_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tnva_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  // Sequencer
  tnva_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  // Slot storage and result register
  tnva_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // A note-on is always the only result of its item
  a_on_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_ON) |-> m_tlast)
    else $error("note-on without last flag");

  // Note-off carries zero velocity
  a_off_zero_vel: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_OFF) |-> (m_tdata[13:7] == '0))
    else $error("note-off with nonzero velocity");

  // One item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while previous item in work");

endmodule

// File: tb/sv/tnva_checker.sv
// ----------------------------------------------------------------------------
// tnva_checker
// Watches the request, event and register channels of the voice allocator.
// Keeps its own copy of the voice pool and millisecond clock. Predicts the
// note-on / note-off events of every accepted item and compares each
// accepted event, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module tnva_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [tnva_pkg::S_DATA_W-1:0]     s_tdata,
  input  logic [0:0]                        s_tuser,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [tnva_pkg::M_DATA_W-1:0]     m_tdata,
  input  logic [0:0]                        m_tuser,
  input  logic                              m_tlast,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [tnva_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tnva_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                pending,
  output int                                errors,
  output int                                items_seen,
  output int                                events_seen,
  output int                                refused
);
  timeunit 1ns;
  timeprecision 1ps;

  import tnva_pkg::*;

  typedef struct packed {
    kind_t             kind;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [CHAN_W-1:0] chan;
    logic [4:0]        slot;
    logic              last;
  } voice_event_t;

  // Shadow voice pool and configuration
  logic [NOTE_W-1:0] voice_note   [VOICE_COUNT];
  logic [VEL_W-1:0]  voice_vel    [VOICE_COUNT];
  logic [TIME_W-1:0] voice_expiry [VOICE_COUNT];
  logic [CHAN_W-1:0] voice_chan   [VOICE_COUNT];
  logic [TIME_W-1:0] clock_ms;
  logic              per_note_mode;
  logic [CHAN_W-1:0] dflt_chan;

  voice_event_t expected_events[$];

  // Work out the events of one request or tick and queue them
  task automatic allocate_or_expire(input op_t op, input logic [S_DATA_W-1:0] data);
    voice_event_t      ev;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [HOLD_W-1:0] hold;
    logic [CHAN_W-1:0] chan;
    int                slot_taken;
    int                last_off;
    note       = data[6:0];
    vel        = data[13:7];
    hold       = data[29:14];
    chan       = data[34:30];
    slot_taken = -1;
    last_off   = -1;
    if (op == OP_NOTE) begin
      // take the lowest free slot, or drop the request on a full pool
      for (int i = 0; i < VOICE_COUNT; i++) begin
        if (slot_taken < 0 && voice_vel[i] == '0) begin
          slot_taken      = i;
          voice_note[i]   = note;
          voice_vel[i]    = vel;
          voice_expiry[i] = clock_ms + TIME_W'(hold);
          voice_chan[i]   = chan;
          ev.kind = KIND_ON;
          ev.note = note;
          ev.vel  = vel;
          ev.chan = per_note_mode ? chan : dflt_chan;
          ev.slot = 5'(i);
          ev.last = 1'b1;
          expected_events.push_back(ev);
        end
      end
      if (slot_taken < 0) begin
        refused++;
      end
    end else begin
      // advance the clock, then release every expired held slot in order
      clock_ms = clock_ms + 1;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        if (voice_vel[i] != '0 && voice_expiry[i] <= clock_ms) begin
          last_off = i;
        end
      end
      for (int i = 0; i < VOICE_COUNT; i++) begin
        if (voice_vel[i] != '0 && voice_expiry[i] <= clock_ms) begin
          ev.kind = KIND_OFF;
          ev.note = voice_note[i];
          ev.vel  = '0;
          ev.chan = per_note_mode ? voice_chan[i] : dflt_chan;
          ev.slot = 5'(i);
          ev.last = (i == last_off);
          expected_events.push_back(ev);
          voice_vel[i] = '0;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    voice_event_t want;
    voice_event_t got;
    if (rst) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        voice_note[i]   = '0;
        voice_vel[i]    = '0;
        voice_expiry[i] = '0;
        voice_chan[i]   = CHAN_W'(1);
      end
      clock_ms      = '0;
      per_note_mode = 1'b0;
      dflt_chan     = CHAN_W'(1);
      expected_events.delete();
    end else begin
      // track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_PER_NOTE:   per_note_mode = cfg_data[0];
          REG_DEFAULT_CH: dflt_chan     = cfg_data;
          default: ;
        endcase
      end

      // compare each accepted event with the oldest prediction
      if (m_tvalid && m_tready) begin
        events_seen++;
        got.kind = kind_t'(m_tuser[0]);
        got.note = m_tdata[6:0];
        got.vel  = m_tdata[13:7];
        got.chan = m_tdata[18:14];
        got.slot = m_tdata[23:19];
        got.last = m_tlast;
        if (expected_events.size() == 0) begin
          if (errors < 10) begin
            $display("%0t: unexpected event kind=%0d note=%0d vel=%0d ch=%0d slot=%0d last=%0d",
                     $time, got.kind, got.note, got.vel, got.chan, got.slot, got.last);
          end
          errors++;
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            if (errors < 10) begin
              $display("%0t: event mismatch", $time);
              $display("  expected kind=%0d note=%0d vel=%0d ch=%0d slot=%0d last=%0d",
                       want.kind, want.note, want.vel, want.chan, want.slot, want.last);
              $display("  actual   kind=%0d note=%0d vel=%0d ch=%0d slot=%0d last=%0d",
                       got.kind, got.note, got.vel, got.chan, got.slot, got.last);
            end
            errors++;
          end
        end
      end

      // predict from each accepted item
      if (s_tvalid && s_tready) begin
        items_seen++;
        allocate_or_expire(op_t'(s_tuser[0]), s_tdata);
      end
    end
    pending <= expected_events.size();
  end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the timed note voice allocator.
// Runs a directed pass over pool fill, pool full, zero velocity, channel
// modes and multi-slot expiry, then three random phases with changing
// register settings and back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tnva_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_DELAY = 16;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [S_DATA_W-1:0]    s_tdata   = '0;
  logic [0:0]             s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_DATA_W-1:0]    m_tdata;
  logic [0:0]             m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int pending;
  int errors;
  int items_seen;
  int events_seen;
  int refused;
  int cycle_count = 0;
  int reg_writes  = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  timed_note_voice_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tnva_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pending     (pending),
    .errors      (errors),
    .items_seen  (items_seen),
    .events_seen (events_seen),
    .refused     (refused)
  );

  always #6 clk = ~clk;

  // Stall the event channel at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Pack one request: note, velocity, hold, channel from bit 0 up
  function automatic logic [S_DATA_W-1:0] pack_request(input logic [NOTE_W-1:0] note,
                                                       input logic [VEL_W-1:0]  vel,
                                                       input logic [HOLD_W-1:0] hold,
                                                       input logic [CHAN_W-1:0] chan);
    return {5'b0, chan, hold, vel, note};
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input op_t op, input logic [S_DATA_W-1:0] data);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_note(input int note, input int vel, input int hold, input int chan);
    send_item(OP_NOTE, pack_request(NOTE_W'(note), VEL_W'(vel), HOLD_W'(hold), CHAN_W'(chan)));
  endtask

  task automatic send_tick();
    send_item(OP_TICK, pack_request(NOTE_W'($urandom_range(0, 127)),
                                    VEL_W'($urandom_range(0, 127)),
                                    HOLD_W'($urandom_range(0, 65535)),
                                    CHAN_W'($urandom_range(0, 31))));
  endtask

  // Drop valid, wait for every predicted event, then let a tick with no
  // note-off run out
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_DELAY) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic set_config(input logic per_note, input logic [CFG_DATA_W-1:0] dflt);
    wait_idle();
    write_reg(REG_PER_NOTE, CFG_DATA_W'(per_note));
    write_reg(REG_DEFAULT_CH, dflt);
  endtask

  // Mostly short holds so voices cycle; long holds ride mostly on zero
  // velocity requests so the pool does not clog; ticks carry random payload
  task automatic run_random(input int count);
    int pick;
    int vel;
    int hold;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_tick();
      end else begin
        vel  = $urandom_range(1, 127);
        hold = $urandom_range(0, 12);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          vel  = 0;
          hold = $urandom_range(0, 65535);
        end else if (pick < 11) begin
          hold = $urandom_range(0, 65535);
        end
        send_note($urandom_range(0, 127), vel, hold, $urandom_range(0, 31));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: default channel mode
    set_config(1'b0, CFG_DATA_W'(1));
    send_note(0, 127, 0, 16);
    send_note(127, 1, 0, 1);
    // zero velocity: note-on goes out, slot stays free
    send_note(55, 0, 65535, 31);
    // both held slots expire together, then a tick with nothing expired
    send_tick();
    send_tick();
    // fill the whole pool with the same expiry
    for (int k = 0; k < VOICE_COUNT; k++) begin
      send_note(10 + k, (k == 0) ? 127 : 16 * k, 2, (k % 2) ? 31 : 0);
    end
    // pool full: request is dropped
    send_note(99, 64, 0, 5);
    send_tick();
    send_tick();

    // Directed: per-note channel mode, out-of-range channels pass through
    set_config(1'b1, CFG_DATA_W'(16));
    send_note(1, 100, 0, 0);
    send_note(2, 101, 0, 31);
    send_note(3, 102, 0, 16);
    send_note(4, 103, 0, 1);
    send_note(5, 0, 0, 7);
    send_tick();

    // Random: busy sender, slow receiver
    set_config(1'b0, CFG_DATA_W'(16));
    tx_idle_pct = 10;
    rx_idle_pct = 69;
    run_random(135);

    // Random: slow sender, busy receiver, with a full drain midway
    set_config(1'b1, CFG_DATA_W'(31));
    tx_idle_pct = 69;
    rx_idle_pct = 10;
    run_random(70);
    wait_idle();
    run_random(65);

    // Random: no idling on either side
    set_config(1'($urandom_range(0, 1)), CFG_DATA_W'($urandom_range(0, 31)));
    write_reg(REG_DEFAULT_CH, CFG_DATA_W'(0));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(135);

    wait_idle();

    $display("Covered %0d items and %0d events, %0d requests dropped on a full pool,",
             items_seen, events_seen, refused);
    $display("%0d register writes across both channel modes.", reg_writes);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
